[rtl/asg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asg_pkg: shared types and constants for the audio squelch gate
// Register indexes, fixed-point widths, reset values, the sequencer state and
// gain mode types, and a rate saturation function.
// ----------------------------------------------------------------------------
package asg_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE  = 2'd2;

  // fixed-point formats
  localparam int THR_W     = 16;
  localparam int RATE_W    = 17;
  localparam int GAIN_W    = 16;
  localparam int FRAC_W    = 8;   // fraction bits of the level average
  localparam int AVG_SHIFT = 3;   // average weight 1/8
  localparam int RATE_SH   = 16;  // rate scale 65536 = 1.0
  localparam int GAIN_SH   = 15;  // gain scale 32768 = 1.0

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;
  localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;

  localparam logic [THR_W-1:0]  THRESHOLD_RST   = 16'd1024;
  localparam logic [RATE_W-1:0] ATTACK_RATE_RST = 17'd6554;
  localparam logic [RATE_W-1:0] DECAY_RATE_RST  = 17'd65209;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_GAIN_UPD,
    ST_OUT_MUL,
    ST_OUT_DRV
  } asg_state_t;

  typedef enum logic [1:0] {
    GM_HOLD,
    GM_QUIET,
    GM_LOUD
  } gain_mode_t;

  function automatic logic [RATE_W-1:0] sat_rate(input logic [RATE_W-1:0] r);
    sat_rate = (r > RATE_ONE) ? RATE_ONE : r;
  endfunction

endpackage : asg_pkg
`default_nettype wire

[rtl/asg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asg_if: channel interfaces of the audio squelch gate
// Sample input, sample output and configuration write channels, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface asg_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface : asg_in_if

interface asg_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface : asg_out_if

interface asg_cfg_if
  import asg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : asg_cfg_if
`default_nettype wire

[rtl/asg_mul_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asg_mul_unit: shared unsigned multiplier with registered product
// Loads a new product when enabled and holds it otherwise.
// ----------------------------------------------------------------------------
module asg_mul_unit #(
  parameter int A_W = 16,
  parameter int B_W = 17
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic      [A_W+B_W-1:0] p
);

  logic [A_W+B_W-1:0] p_r;
  logic [A_W+B_W-1:0] p_nxt;

  always_comb begin
    p_nxt = (A_W + B_W)'(a) * (A_W + B_W)'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule : asg_mul_unit
`default_nettype wire

[rtl/audio_squelch_gate.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_squelch_gate: noise gate with attack/decay gain for signed audio
// Tracks a smoothed sample level and scales each sample by a Q1.15 gain
// that decays while the level is quiet and recovers while it is loud.
// ----------------------------------------------------------------------------
// usage
//   in_chan   : one signed sample per word, taken while in_chan.ready is high
//   out_chan  : one scaled sample per input word, in order
//   cfg_chan  : register writes (threshold, attack_rate, decay_rate), always
//               ready; write only while no sample is in flight
// timing
//   a sample runs in steps: the accept cycle updates the level average,
//   then the one shared multiplier runs twice (gain update, output scaling)
//   with a gain add step between and an output load step at the end;
//   the result is registered into the out_chan output register in that load step
//   the five sequencer states run once per sample; in_chan is ready only in ST_IDLE
// stall
//   out_chan has its own output register, so the next sample is taken while
//   a result waits; a second result waits in the sequencer until the output
//   register frees, and no further sample is taken meanwhile
// reset
//   rst_n low clears the level average to zero, sets gain to 1.0 and loads
//   the register defaults; no result is pending afterwards
// ----------------------------------------------------------------------------
module audio_squelch_gate
  import asg_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  asg_cfg_if.sink     cfg_chan,
  asg_in_if.sink      in_chan,
  asg_out_if.source   out_chan
);

  localparam int AVG_W  = SAMPLE_WIDTH + FRAC_W;
  localparam int SUM_W  = AVG_W + AVG_SHIFT;
  localparam int CMP_W  = (AVG_W + 2 > THR_W + FRAC_W) ? AVG_W + 2 : THR_W + FRAC_W;
  localparam int MUL_AW = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
  localparam int MUL_PW = MUL_AW + RATE_W;

  // configuration registers
  logic [THR_W-1:0]  threshold_r;
  logic [RATE_W-1:0] attack_rate_r;
  logic [RATE_W-1:0] decay_rate_r;

  // state
  asg_state_t              state_r, state_nxt;
  gain_mode_t              mode_r, mode_nxt;
  logic [AVG_W-1:0]        avg_r, avg_nxt;
  logic [GAIN_W-1:0]       gain_r, gain_nxt;
  logic [SAMPLE_WIDTH-1:0] mag_r, mag_nxt;
  logic                    neg_r;
  logic                    out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_r;

  // control
  logic in_acc;
  logic out_acc;
  logic out_load;
  logic mul_en;
  logic mul_out_sel;

  // datapath
  logic [SAMPLE_WIDTH-1:0] in_bits;
  logic [SUM_W-1:0]        avg_sum;
  logic [CMP_W-1:0]        avg_x3;
  logic [CMP_W-1:0]        avg_ext;
  logic [CMP_W-1:0]        thr_fx;
  logic                    is_quiet;
  logic                    is_loud;
  logic [MUL_AW-1:0]       mul_a;
  logic [RATE_W-1:0]       mul_b;
  logic [MUL_PW-1:0]       mul_p;
  logic [RATE_W-1:0]       prod_hi;
  logic [RATE_W-1:0]       gain_sum;
  logic [SAMPLE_WIDTH-1:0] scaled;
  logic [SAMPLE_WIDTH-1:0] res;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_valid_r && out_chan.ready;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESHOLD_RST;
      attack_rate_r <= ATTACK_RATE_RST;
      decay_rate_r  <= DECAY_RATE_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_THRESHOLD:   threshold_r   <= cfg_chan.data[THR_W-1:0];
        REG_ATTACK_RATE: attack_rate_r <= cfg_chan.data;
        REG_DECAY_RATE:  decay_rate_r  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // magnitude and level average, done in the accept cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    in_bits = in_chan.sample_in;
    mag_nxt = in_bits[SAMPLE_WIDTH-1] ? ((~in_bits) + SAMPLE_WIDTH'(1)) : in_bits;
    // 7*avg + mag*256 as 8*avg - avg + mag*256
    avg_sum = (SUM_W'(avg_r) << AVG_SHIFT) - SUM_W'(avg_r)
            + (SUM_W'(mag_nxt) << FRAC_W);
    avg_nxt = avg_sum[SUM_W-1:AVG_SHIFT];
  end

  // level compare against the threshold in avg units
  always_comb begin
    avg_ext  = CMP_W'(avg_r);
    avg_x3   = (avg_ext << 1) + avg_ext;
    thr_fx   = CMP_W'(threshold_r) << FRAC_W;
    is_quiet = avg_x3 < thr_fx;
    is_loud  = avg_ext > thr_fx;
  end

  // ---------------------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    if (mul_out_sel) begin
      mul_a = MUL_AW'(mag_r);
      mul_b = RATE_W'(gain_r);
    end else if (is_quiet) begin
      mul_a = MUL_AW'(gain_r);
      mul_b = sat_rate(decay_rate_r);
    end else begin
      mul_a = MUL_AW'(GAIN_ONE - gain_r);
      mul_b = sat_rate(attack_rate_r);
    end
  end

  asg_mul_unit #(
    .A_W (MUL_AW),
    .B_W (RATE_W)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // gain update from the registered product
  always_comb begin
    prod_hi  = mul_p[RATE_SH+RATE_W-1:RATE_SH];
    gain_sum = RATE_W'(gain_r);
    unique case (mode_r)
      GM_QUIET: gain_sum = prod_hi;
      GM_LOUD:  gain_sum = RATE_W'(gain_r) + prod_hi;
      GM_HOLD:  gain_sum = RATE_W'(gain_r);
      default:  gain_sum = RATE_W'(gain_r);
    endcase
    if (gain_sum > RATE_W'(GAIN_ONE)) begin
      gain_nxt = GAIN_ONE;
    end else begin
      gain_nxt = gain_sum[GAIN_W-1:0];
    end
  end

  // output scaling, truncated toward zero by working on the magnitude
  always_comb begin
    scaled = mul_p[SAMPLE_WIDTH+GAIN_SH-1:GAIN_SH];
    res    = neg_r ? ((~scaled) + SAMPLE_WIDTH'(1)) : scaled;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_chan.valid) state_nxt = ST_GAIN_MUL;
      ST_GAIN_MUL: state_nxt = ST_GAIN_UPD;
      ST_GAIN_UPD: state_nxt = ST_OUT_MUL;
      ST_OUT_MUL:  state_nxt = ST_OUT_DRV;
      ST_OUT_DRV:  if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    mul_en        = 1'b0;
    mul_out_sel   = 1'b0;
    out_load      = 1'b0;
    mode_nxt      = mode_r;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
      end
      ST_GAIN_MUL: begin
        mul_en = 1'b1;
        priority if (is_quiet) begin
          mode_nxt = GM_QUIET;
        end else if (is_loud) begin
          mode_nxt = GM_LOUD;
        end else begin
          mode_nxt = GM_HOLD;
        end
      end
      ST_GAIN_UPD: begin
      end
      ST_OUT_MUL: begin
        mul_en      = 1'b1;
        mul_out_sel = 1'b1;
      end
      ST_OUT_DRV: begin
        mul_out_sel = 1'b1;
        out_load    = !out_valid_r || out_chan.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= GM_HOLD;
      avg_r       <= '0;
      gain_r      <= GAIN_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      if (in_acc) begin
        avg_r <= avg_nxt;
      end
      if (state_r == ST_GAIN_UPD) begin
        gain_r <= gain_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_r <= mag_nxt;
      neg_r <= in_bits[SAMPLE_WIDTH-1];
    end
    if (out_load) begin
      sample_out_r <= $signed(res);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = sample_out_r;

endmodule : audio_squelch_gate
`default_nettype wire

[rtl/asg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asg_checker: port-level checks for the audio squelch gate
// Watches the sample channels for word counts and stall behavior.
// ----------------------------------------------------------------------------
module asg_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("output word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken again right after an accept");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two words in flight");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("output word without a matching input word");

endmodule : asg_checker

bind audio_squelch_gate asg_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_asg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .sample_out (out_chan.sample_out)
);
`default_nettype wire
